>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define TPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define TPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

>>> rtl/core/tps_pkg.sv
`default_nettype none

package tps_pkg;

  localparam int unsigned CRD_W      = 32;
  localparam int unsigned DIF_W      = CRD_W + 1;
  localparam int unsigned PRD_W      = 2 * CRD_W;
  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = CRD_W / DIV_STEPS;
  // magnitude stage, product stage, divider stages, result stage
  localparam int unsigned LERP_LAT   = DIV_STAGES + 3;
  localparam int unsigned NRM_W      = 2 * DIF_W + 1;
  // normal is ready after the product and difference registers, points after the interpolation lanes
  localparam int unsigned NRM_DLY    = LERP_LAT - 2;
  localparam int unsigned NLO_W      = 34;
  localparam int unsigned LO_W       = NLO_W + 1 + DIF_W;
  localparam int unsigned HI_W       = NRM_W - NLO_W + DIF_W;
  localparam int unsigned CZ_W       = NRM_W + DIF_W + 1;
  localparam int unsigned ORI_LAT    = 3;
  localparam int unsigned PIPE_DEPTH = 1 + LERP_LAT + ORI_LAT + 1;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [DIF_W-1:0] dif_t;

  typedef struct packed {
    crd_t base;
    dif_t span;
    dif_t rise;
    dif_t run;
  } lerp_op_t;

  typedef struct packed {
    dif_t ex;
    dif_t ey;
    dif_t ez;
    dif_t fx;
    dif_t fy;
    dif_t fz;
  } edge_pair_t;

  typedef struct packed {
    crd_t x1;
    crd_t y1;
    crd_t x2;
    crd_t y2;
  } seg_t;

endpackage

`default_nettype wire

>>> rtl/core/tps_lerp.sv
`default_nettype none

module tps_lerp import tps_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  lerp_op_t op_i,
  output crd_t     res_o
);

  function automatic logic [CRD_W-1:0] mag(input dif_t v);
    dif_t n;
    n = -v;
    return v[DIF_W-1] ? n[CRD_W-1:0] : v[CRD_W-1:0];
  endfunction

  // one restoring step: {rem, dividend low / quotient} shifts left by one
  function automatic logic [PRD_W-1:0] div_step(input logic [PRD_W-1:0] acc,
                                                 input logic [CRD_W-1:0] d);
    logic [CRD_W:0]   t;
    logic [CRD_W:0]   s;
    logic [CRD_W-1:0] r;
    logic             ge;
    t  = acc[PRD_W-1:CRD_W-1];
    s  = t - {1'b0, d};
    ge = (t >= {1'b0, d});
    r  = ge ? s[CRD_W-1:0] : t[CRD_W-1:0];
    return {r, acc[CRD_W-2:0], ge};
  endfunction

  // magnitude stage
  logic [CRD_W-1:0] dm_q, tm_q, zm_q;
  logic             neg_q;
  crd_t             a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm_q  <= mag(op_i.span);
      tm_q  <= mag(op_i.rise);
      zm_q  <= mag(op_i.run);
      neg_q <= op_i.span[DIF_W-1] ^ op_i.rise[DIF_W-1] ^ op_i.run[DIF_W-1];
      a_q   <= op_i.base;
    end
  end

  // product stage
  logic [PRD_W-1:0] prod_d, prod_q;
  logic [CRD_W-1:0] zp_q;
  logic             np_q;
  crd_t             ap_q;

  assign prod_d = dm_q * tm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      zp_q   <= zm_q;
      np_q   <= neg_q;
      ap_q   <= a_q;
    end
  end

  // divider stages
  logic [PRD_W-1:0] acc_q [DIV_STAGES];
  logic [CRD_W-1:0] d_q   [DIV_STAGES];
  logic             n_q   [DIV_STAGES];
  crd_t             b_q   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [PRD_W-1:0] acc_in, acc_d;
    logic [CRD_W-1:0] d_in;
    logic             n_in;
    crd_t             b_in;

    if (s == 0) begin : g_first
      assign acc_in = prod_q;
      assign d_in   = zp_q;
      assign n_in   = np_q;
      assign b_in   = ap_q;
    end else begin : g_next
      assign acc_in = acc_q[s-1];
      assign d_in   = d_q[s-1];
      assign n_in   = n_q[s-1];
      assign b_in   = b_q[s-1];
    end

    always_comb begin
      acc_d = acc_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        acc_d = div_step(acc_d, d_in);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= acc_d;
        d_q[s]   <= d_in;
        n_q[s]   <= n_in;
        b_q[s]   <= b_in;
      end
    end
  end

  // result stage
  crd_t res_q, quo;

  assign quo = crd_t'(acc_q[DIV_STAGES-1][CRD_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= n_q[DIV_STAGES-1] ? b_q[DIV_STAGES-1] - quo : b_q[DIV_STAGES-1] + quo;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/core/tps_orient.sv
`default_nettype none

module tps_orient import tps_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  edge_pair_t edges_i,
  input  seg_t       seg_i,
  output logic       swap_o
);

  logic signed [2*DIF_W-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [NRM_W-1:0]   nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= $signed(edges_i.ey) * $signed(edges_i.fz);
      pb_q <= $signed(edges_i.ez) * $signed(edges_i.fy);
      pc_q <= $signed(edges_i.ez) * $signed(edges_i.fx);
      pd_q <= $signed(edges_i.ex) * $signed(edges_i.fz);
      nx_q <= NRM_W'(pa_q) - NRM_W'(pb_q);
      ny_q <= NRM_W'(pc_q) - NRM_W'(pd_q);
    end
  end

  // hold the normal until the crossing points arrive
  logic signed [NRM_W-1:0] nxd_q [NRM_DLY];
  logic signed [NRM_W-1:0] nyd_q [NRM_DLY];

  for (genvar i = 0; i < NRM_DLY; i++) begin : g_dly
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nxd_q[i] <= nx_q;
          nyd_q[i] <= ny_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nxd_q[i] <= nxd_q[i-1];
          nyd_q[i] <= nyd_q[i-1];
        end
      end
    end
  end

  dif_t                    dx_q, dy_q;
  logic signed [NRM_W-1:0] nx1_q, ny1_q;
  logic signed [LO_W-1:0]  alo_q, blo_q;
  logic signed [HI_W-1:0]  ahi_q, bhi_q;
  logic [CZ_W-1:0]         sa_q, sb_q, cz;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= DIF_W'(seg_i.x2) - DIF_W'(seg_i.x1);
      dy_q  <= DIF_W'(seg_i.y2) - DIF_W'(seg_i.y1);
      nx1_q <= nxd_q[NRM_DLY-1];
      ny1_q <= nyd_q[NRM_DLY-1];
      // split the normal into an unsigned low part and a signed high part
      alo_q <= $signed({1'b0, nx1_q[NLO_W-1:0]}) * dy_q;
      ahi_q <= $signed(nx1_q[NRM_W-1:NLO_W]) * dy_q;
      blo_q <= $signed({1'b0, ny1_q[NLO_W-1:0]}) * dx_q;
      bhi_q <= $signed(ny1_q[NRM_W-1:NLO_W]) * dx_q;
      sa_q  <= {ahi_q[HI_W-1], ahi_q, {NLO_W{1'b0}}}
             + {{(CZ_W-LO_W){alo_q[LO_W-1]}}, alo_q};
      sb_q  <= {bhi_q[HI_W-1], bhi_q, {NLO_W{1'b0}}}
             + {{(CZ_W-LO_W){blo_q[LO_W-1]}}, blo_q};
    end
  end

  assign cz     = sa_q - sb_q;
  assign swap_o = cz[CZ_W-1];

endmodule

`default_nettype wire

>>> rtl/core/triangle_plane_slice.sv
// throughput: one transaction per cycle; a valid result held by stall_i freezes the whole pipeline
// latency is set mostly by the four pipelined dividers (2 quotient bits per stage, 16 stages)
// reset clears all valid bits and the output valid; payload registers are not reset
`default_nettype none

module triangle_plane_slice import tps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  crd_t vertex0_x_i,
  input  crd_t vertex0_y_i,
  input  crd_t vertex0_z_i,
  input  crd_t vertex1_x_i,
  input  crd_t vertex1_y_i,
  input  crd_t vertex1_z_i,
  input  crd_t vertex2_x_i,
  input  crd_t vertex2_y_i,
  input  crd_t vertex2_z_i,
  input  crd_t slice_height_i,
  output logic valid_o,
  input  logic stall_i,
  output logic hit_o,
  output crd_t start_x_o,
  output crd_t start_y_o,
  output crd_t end_x_o,
  output crd_t end_y_o
);

  // pipeline advances unless the output register holds an untaken result
  logic out_vld_q;
  logic en;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = out_vld_q && stall_i;
  assign valid_o = out_vld_q;

  // ---------------------------------------------------------------
  // capture stage: edge differences, crossing test, edge selection
  // ---------------------------------------------------------------
  crd_t       vx [3];
  crd_t       vy [3];
  crd_t       vz [3];
  dif_t       ddx [3];
  dif_t       ddy [3];
  dif_t       ddz [3];
  dif_t       dhz [3];
  logic [2:0] le, ge, crs;
  logic [1:0] sel1, sel2;
  logic       hit_c;
  lerp_op_t   op_c [4];
  edge_pair_t edges_c;

  assign vx[0] = vertex0_x_i;
  assign vy[0] = vertex0_y_i;
  assign vz[0] = vertex0_z_i;
  assign vx[1] = vertex1_x_i;
  assign vy[1] = vertex1_y_i;
  assign vz[1] = vertex1_z_i;
  assign vx[2] = vertex2_x_i;
  assign vy[2] = vertex2_y_i;
  assign vz[2] = vertex2_z_i;

  always_comb begin
    int j;
    for (int k = 0; k < 3; k++) begin
      j      = (k == 2) ? 0 : k + 1;
      // a vertex exactly on the plane counts as below
      le[k]  = vz[k] <= slice_height_i;
      ge[k]  = vz[k] >= slice_height_i;
      ddx[k] = DIF_W'(vx[j]) - DIF_W'(vx[k]);
      ddy[k] = DIF_W'(vy[j]) - DIF_W'(vy[k]);
      ddz[k] = DIF_W'(vz[j]) - DIF_W'(vz[k]);
      dhz[k] = DIF_W'(slice_height_i) - DIF_W'(vz[k]);
    end
    for (int k = 0; k < 3; k++) begin
      j      = (k == 2) ? 0 : k + 1;
      crs[k] = le[k] ^ le[j];
    end
  end

  assign hit_c = !((&ge) || (&le));

  // with a hit, sel1 and sel2 take the crossing edges in edge order
  assign sel1 = crs[0] ? 2'd0 : 2'd1;
  assign sel2 = (crs[0] && crs[1]) ? 2'd1 : 2'd2;

  assign op_c[0] = '{base: vx[sel1], span: ddx[sel1], rise: dhz[sel1], run: ddz[sel1]};
  assign op_c[1] = '{base: vy[sel1], span: ddy[sel1], rise: dhz[sel1], run: ddz[sel1]};
  assign op_c[2] = '{base: vx[sel2], span: ddx[sel2], rise: dhz[sel2], run: ddz[sel2]};
  assign op_c[3] = '{base: vy[sel2], span: ddy[sel2], rise: dhz[sel2], run: ddz[sel2]};

  // normal = (v1 - v0) x (v2 - v1)
  assign edges_c = '{ex: ddx[0], ey: ddy[0], ez: ddz[0],
                     fx: ddx[1], fy: ddy[1], fz: ddz[1]};

  lerp_op_t   op_q [4];
  edge_pair_t edges_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q    <= op_c;
      edges_q <= edges_c;
    end
  end

  // ---------------------------------------------------------------
  // valid and hit travel alongside the data
  // ---------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-2:0] hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= {hit_q[PIPE_DEPTH-3:0], hit_c};
    end
  end

  assign out_vld_q = vld_q[PIPE_DEPTH-1];

  // ---------------------------------------------------------------
  // four interpolation lanes: p1.x, p1.y, p2.x, p2.y
  // ---------------------------------------------------------------
  crd_t res [4];
  seg_t seg_c;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    tps_lerp u_lerp (
      .clk_i (clk_i),
      .en_i  (en),
      .op_i  (op_q[l]),
      .res_o (res[l])
    );
  end

  assign seg_c = '{x1: res[0], y1: res[1], x2: res[2], y2: res[3]};

  // ---------------------------------------------------------------
  // orientation: sign of z of normal x (p2 - p1) picks the order
  // ---------------------------------------------------------------
  logic swap;

  tps_orient u_orient (
    .clk_i   (clk_i),
    .en_i    (en),
    .edges_i (edges_q),
    .seg_i   (seg_c),
    .swap_o  (swap)
  );

  // points wait while the orientation products settle
  seg_t pd_q [ORI_LAT];

  for (genvar i = 0; i < ORI_LAT; i++) begin : g_pdly
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          pd_q[i] <= seg_c;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          pd_q[i] <= pd_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // output register: endpoints, swapped when swap is set, zeros when there is no hit
  // ---------------------------------------------------------------
  logic hit_out_q;
  crd_t sx_q, sy_q, ex_q, ey_q;
  seg_t fin;

  assign fin = pd_q[ORI_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_out_q <= hit_q[PIPE_DEPTH-2];
      if (!hit_q[PIPE_DEPTH-2]) begin
        sx_q <= '0;
        sy_q <= '0;
        ex_q <= '0;
        ey_q <= '0;
      end else if (swap) begin
        sx_q <= fin.x2;
        sy_q <= fin.y2;
        ex_q <= fin.x1;
        ey_q <= fin.y1;
      end else begin
        sx_q <= fin.x1;
        sy_q <= fin.y1;
        ex_q <= fin.x2;
        ey_q <= fin.y2;
      end
    end
  end

  assign hit_o     = hit_out_q;
  assign start_x_o = sx_q;
  assign start_y_o = sy_q;
  assign end_x_o   = ex_q;
  assign end_y_o   = ey_q;

endmodule

`default_nettype wire

>>> rtl/core/tps_checker.sv
`default_nettype none

`include "assert_macros.svh"

module tps_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        stall_o,
  input wire        valid_o,
  input wire        stall_i,
  input wire        hit_o,
  input wire [31:0] start_x_o,
  input wire [31:0] start_y_o,
  input wire [31:0] end_x_o,
  input wire [31:0] end_y_o
);

  logic         seg_zero;
  logic [128:0] res_bus;

  assign seg_zero = (start_x_o == 32'd0) && (start_y_o == 32'd0)
                 && (end_x_o == 32'd0) && (end_y_o == 32'd0);
  assign res_bus  = {hit_o, start_x_o, start_y_o, end_x_o, end_y_o};

  // a miss carries an all-zero segment
  `TPS_ASSERT_IMP(a_miss_zero, valid_o && !hit_o, seg_zero)

  // input side backs up only behind a held result
  `TPS_ASSERT_IMP(a_stall_cause, stall_o, valid_o && stall_i)

  // a held result keeps its payload
  `TPS_ASSERT_NXT(a_hold, valid_o && stall_i, valid_o && $stable(res_bus))

endmodule

bind triangle_plane_slice tps_checker u_tps_checker (.*);

`default_nettype wire

>>> tb/triangle_plane_slice_tb.sv
`default_nettype none

module triangle_plane_slice_tb;
  import tps_pkg::*;

  localparam int unsigned LATENCY = 24;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;

  // one triangle and its cutting height
  typedef struct {
    crd_t vx[3];
    crd_t vy[3];
    crd_t vz[3];
    crd_t h;
  } tri_t;

  // one segment result
  typedef struct {
    logic hit;
    crd_t sx;
    crd_t sy;
    crd_t ex;
    crd_t ey;
  } slice_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  crd_t vertex0_x_i = '0, vertex0_y_i = '0, vertex0_z_i = '0;
  crd_t vertex1_x_i = '0, vertex1_y_i = '0, vertex1_z_i = '0;
  crd_t vertex2_x_i = '0, vertex2_y_i = '0, vertex2_z_i = '0;
  crd_t slice_height_i = '0;
  logic valid_o;
  logic stall_i = 1'b1;
  logic hit_o;
  crd_t start_x_o, start_y_o, end_x_o, end_y_o;

  slice_t segments_due[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit hold_output = 1'b0;
  bit sink_enable = 1'b0;

  triangle_plane_slice i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .vertex0_x_i, .vertex0_y_i, .vertex0_z_i,
    .vertex1_x_i, .vertex1_y_i, .vertex1_z_i,
    .vertex2_x_i, .vertex2_y_i, .vertex2_z_i,
    .slice_height_i, .valid_o, .stall_i, .hit_o,
    .start_x_o, .start_y_o, .end_x_o, .end_y_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // edge interpolation a + trunc((b-a)*(h-za)/(zb-za)), exact in wide signed math
  function automatic logic signed [63:0] lerp_edge(
    logic signed [63:0] a, logic signed [63:0] b,
    logic signed [63:0] za, logic signed [63:0] zb, logic signed [63:0] h);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] quo;
    num = 128'(b - a) * 128'(h - za);
    den = 128'(zb - za);
    quo = num / den;
    return a + 64'(quo);
  endfunction

  // segment cut from the triangle by the plane z = h
  function automatic slice_t slice_triangle(tri_t t);
    slice_t r;
    logic signed [63:0] x[3], y[3], z[3], h;
    logic signed [63:0] px[2], py[2], tmp;
    logic signed [127:0] nx, ny, cz;
    int found;
    int j;
    r = '{1'b0, '0, '0, '0, '0};
    found = 0;
    for (int k = 0; k < 3; k++) begin
      x[k] = t.vx[k];
      y[k] = t.vy[k];
      z[k] = t.vz[k];
    end
    h = t.h;
    px = '{0, 0};
    py = '{0, 0};
    if ((z[0] >= h && z[1] >= h && z[2] >= h) || (z[0] <= h && z[1] <= h && z[2] <= h))
      return r;
    for (int k = 0; k < 3; k++) begin
      j = (k == 2) ? 0 : k + 1;
      if (found < 2 && ((z[k] <= h && z[j] > h) || (z[j] <= h && z[k] > h))) begin
        px[found] = lerp_edge(x[k], x[j], z[k], z[j], h);
        py[found] = lerp_edge(y[k], y[j], z[k], z[j], h);
        found++;
      end
    end
    if (found < 2) return r;
    nx = 128'(y[1] - y[0]) * 128'(z[2] - z[1]) - 128'(z[1] - z[0]) * 128'(y[2] - y[1]);
    ny = 128'(z[1] - z[0]) * 128'(x[2] - x[1]) - 128'(x[1] - x[0]) * 128'(z[2] - z[1]);
    cz = nx * 128'(py[1] - py[0]) - ny * 128'(px[1] - px[0]);
    if (cz < 0) begin
      tmp = px[0]; px[0] = px[1]; px[1] = tmp;
      tmp = py[0]; py[0] = py[1]; py[1] = tmp;
    end
    r.hit = 1'b1;
    r.sx = px[0][31:0];
    r.sy = py[0][31:0];
    r.ex = px[1][31:0];
    r.ey = py[1][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h expected %h", field, got, want);
    mismatches++;
  endtask

  // drive one triangle and wait for its transaction to be accepted
  task automatic send_triangle(tri_t t);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    segments_due.push_back(slice_triangle(t));
    vertex0_x_i <= t.vx[0]; vertex0_y_i <= t.vy[0]; vertex0_z_i <= t.vz[0];
    vertex1_x_i <= t.vx[1]; vertex1_y_i <= t.vy[1]; vertex1_z_i <= t.vz[1];
    vertex2_x_i <= t.vx[2]; vertex2_y_i <= t.vy[2]; vertex2_z_i <= t.vz[2];
    slice_height_i <= t.h;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
  endtask

  // drop valid after the last transaction of a test
  task automatic idle_input();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic crd_t rand_crd();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return crd_t'($urandom_range(0, 8)) - 4;
      3: return crd_t'($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic tri_t make_triangle(crd_t x0, crd_t y0, crd_t z0, crd_t x1, crd_t y1,
                                         crd_t z1, crd_t x2, crd_t y2, crd_t z2, crd_t h);
    tri_t t;
    t.vx = '{x0, x1, x2};
    t.vy = '{y0, y1, y2};
    t.vz = '{z0, z1, z2};
    t.h = h;
    return t;
  endfunction

  // extremes, no hit either side, vertices on the plane, flat and reversed triangles
  task automatic test_directed();
    crd_t mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    send_triangle(make_triangle(0, 0, 10, 5, 5, 20, 9, 1, 30, 5));
    send_triangle(make_triangle(0, 0, 10, 5, 5, 20, 9, 1, 30, 35));
    send_triangle(make_triangle(0, 0, 10, 5, 5, 20, 9, 1, 30, 10));
    send_triangle(make_triangle(0, 0, 10, 5, 5, 20, 9, 1, 30, 30));
    send_triangle(make_triangle(0, 0, 10, 65536, 0, 20, 0, 65536, 30, 20));
    send_triangle(make_triangle(0, 0, 0, 65536, 0, 100, 0, 65536, 0, 50));
    send_triangle(make_triangle(0, 0, 0, 0, 65536, 100, 65536, 0, 0, 50));
    send_triangle(make_triangle(mn, mn, mn, mx, mx, mx, mn, mx, mn, 0));
    send_triangle(make_triangle(mx, mn, mx, mn, mx, mn, mx, mx, mx, 0));
    send_triangle(make_triangle(mn, mx, mn, mx, mn, mx, mx, mn, 0, mn));
    send_triangle(make_triangle(mn, mx, mn, mx, mn, mx, mx, mn, 0, mx - 1));
    send_triangle(make_triangle(1, 1, 0, 2, 2, 10, 3, 3, 20, 7));
    send_triangle(make_triangle(5, 5, 0, 5, 5, 10, 5, 5, 20, 3));
    send_triangle(make_triangle(-7, 3, -1, 7, -3, 1, 0, 9, 1, 0));
    send_triangle(make_triangle(-7, 3, 1, 7, -3, -1, 0, 9, -1, 0));
    send_triangle(make_triangle(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_triangle(make_triangle(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    idle_input();
  endtask

  // mostly triangles that straddle the plane, plus raw noise
  task automatic test_random(int unsigned count);
    tri_t t;
    crd_t lo, hi;
    for (int unsigned n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        t.vx[k] = rand_crd();
        t.vy[k] = rand_crd();
        t.vz[k] = rand_crd();
      end
      t.h = rand_crd();
      if ($urandom_range(0, 3) != 0) begin
        lo = t.vz[0] < t.vz[1] ? t.vz[0] : t.vz[1];
        hi = t.vz[0] < t.vz[1] ? t.vz[1] : t.vz[0];
        if (lo != hi) begin
          // pick a height strictly inside or on the lower vertex, now and then on any vertex
          t.h = lo + crd_t'(({32'b0, $urandom} * (64'(hi) - 64'(lo))) >> 32);
          if ($urandom_range(0, 7) == 0) t.h = t.vz[$urandom_range(0, 2)];
        end
      end
      send_triangle(t);
    end
    idle_input();
  endtask

  // receiver holds off long enough for the pipeline to back up
  task automatic test_backpressure();
    hold_output = 1'b1;
    fork
      test_random(60);
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
    join
  endtask

  // output side: random stall per transaction, full stall while held
  initial begin
    int unsigned wait_cycles;
    wait (sink_enable);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (wait_cycles != 0 || hold_output) begin
        stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
        while (hold_output) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // compare each accepted result with the oldest expected segment
  always @(posedge clk_i) begin
    slice_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (segments_due.size() == 0) begin
        $display("result with no triangle outstanding");
        mismatches++;
      end else begin
        want = segments_due.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", 32'(hit_o), 32'(want.hit));
        if (start_x_o !== want.sx) report_mismatch("start_x", start_x_o, want.sx);
        if (start_y_o !== want.sy) report_mismatch("start_y", start_y_o, want.sy);
        if (end_x_o !== want.ex) report_mismatch("end_x", end_x_o, want.ex);
        if (end_y_o !== want.ey) report_mismatch("end_y", end_y_o, want.ey);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sink_enable = 1'b1;
    test_directed();
    test_backpressure();
    test_random(340);
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && segments_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
